// ===== src/lfuc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared widths, codes and control structures of the LFU cache.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;
  localparam int CAP_W  = 5;
  localparam int APB_W  = 32;
  localparam int ADDR_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = '0;

  // Item operation codes.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd;
    logic mode_upd;
    logic decide;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_upd;
  } status_t;

endpackage

// ===== src/lfuc_in_if.sv =====
// ----------------------------------------------------------------------------
// lfuc_in_if
// Request channel: one get or put transaction per valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfuc_in_if;
  import lfuc_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

// ===== src/lfuc_out_if.sv =====
// ----------------------------------------------------------------------------
// lfuc_out_if
// Result channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface lfuc_out_if;
  import lfuc_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              evicted;
  logic [KEY_W-1:0]  evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== src/lfuc_ram.sv =====
// ----------------------------------------------------------------------------
// lfuc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lfuc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfuc_ctrl
// Sequencer: clearing sweep, key/victim scan, decision and update sweep.
// ----------------------------------------------------------------------------
module lfuc_ctrl #(
  parameter int ENTRIES = 16,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_busy,
  input  lfuc_pkg::status_t status,
  output lfuc_pkg::cmd_t    cmd,
  output logic [AW-1:0]     addr
);
  import lfuc_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPDATE, ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r) inside
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (cnt_r == CW'(ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN, ST_UPDATE: begin
        cmd.mode_upd = (state_r == ST_UPDATE);
        // The last count issues no read; it lets the final entry's data arrive.
        if (cnt_r == CW'(ENTRIES)) begin
          state_nxt = (state_r == ST_SCAN) ? ST_DECIDE : ST_DONE;
        end else begin
          cmd.rd  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = status.need_upd ? ST_UPDATE : ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign addr     = cnt_r[AW-1:0];

endmodule

// ===== src/lfuc_dp.sv =====
// ----------------------------------------------------------------------------
// lfuc_dp
// Entry store, scan accumulators, replacement decision and entry rewrite.
// ----------------------------------------------------------------------------
module lfuc_dp #(
  parameter int ENTRIES = 16,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfuc_pkg::cmd_t             cmd,
  input  logic [AW-1:0]              addr,
  input  lfuc_pkg::req_t             req,
  input  logic [lfuc_pkg::CAP_W-1:0] capacity,
  output lfuc_pkg::status_t          status,
  output lfuc_pkg::res_t             res
);
  import lfuc_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
    logic [RW-1:0]     rank;
  } rec_t;

  // Memory port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;
  rec_t          ram_rdata;

  // Read pipeline.
  logic          rd_pend_r;
  logic [AW-1:0] rd_idx_r;
  logic          rd_upd_r;

  req_t          req_r;
  logic [CW-1:0] entry_cnt_r, entry_cnt_nxt;

  // Scan results.
  logic              found_ok_r;
  logic [AW-1:0]     found_idx_r;
  logic [RW-1:0]     found_rank_r;
  logic [DATA_W-1:0] found_val_r;
  logic              inv_ok_r;
  logic [AW-1:0]     inv_idx_r;
  logic              vic_ok_r;
  logic [AW-1:0]     vic_idx_r;
  logic [RW-1:0]     vic_rank_r;
  logic [CNT_W-1:0]  vic_count_r;
  logic [KEY_W-1:0]  vic_key_r;

  // Plan for the update sweep.
  logic          touch_r, touch_nxt;
  logic          ow_r, ow_nxt;
  logic          evict_r, evict_nxt;
  logic          ins_r, ins_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  res_t          res_r, res_nxt;

  logic          is_put;
  logic          full;
  logic          scan_en;
  logic          upd_en;
  rec_t          upd_rec;
  logic [RW-1:0] rank_tmp;

  lfuc_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign scan_en = rd_pend_r && !rd_upd_r;
  assign upd_en  = rd_pend_r && rd_upd_r;

  // Decision, evaluated in the cycle after the scan completes.
  assign is_put = (req_r.action == ACT_PUT);
  assign full   = (32'(entry_cnt_r) >= 32'(capacity)) || (32'(entry_cnt_r) >= 32'(ENTRIES));

  always_comb begin
    touch_nxt = 1'b0;
    ow_nxt    = 1'b0;
    evict_nxt = 1'b0;
    ins_nxt   = 1'b0;
    slot_nxt  = inv_idx_r;
    res_nxt   = '0;
    if (!is_put) begin
      touch_nxt          = found_ok_r;
      res_nxt.hit        = found_ok_r;
      res_nxt.read_value = found_ok_r ? found_val_r : '0;
    end else if (capacity != '0) begin
      if (found_ok_r) begin
        touch_nxt   = 1'b1;
        ow_nxt      = 1'b1;
        res_nxt.hit = 1'b1;
      end else begin
        evict_nxt = full && vic_ok_r;
        if (evict_nxt) begin
          // The freed entry is reused unless an earlier entry was already empty.
          ins_nxt             = 1'b1;
          slot_nxt            = (inv_ok_r && (inv_idx_r < vic_idx_r)) ? inv_idx_r : vic_idx_r;
          res_nxt.evicted     = 1'b1;
          res_nxt.evicted_key = vic_key_r;
        end else begin
          ins_nxt = inv_ok_r;
        end
      end
    end
  end

  assign status.need_upd = touch_nxt || evict_nxt || ins_nxt;

  always_comb begin
    entry_cnt_nxt = entry_cnt_r;
    if (cmd.decide) begin
      entry_cnt_nxt = entry_cnt_r - CW'(evict_nxt) + CW'(ins_nxt);
    end
  end

  // Rewrite of one entry during the update sweep.
  always_comb begin
    upd_rec  = ram_rdata;
    rank_tmp = ram_rdata.rank;
    if (touch_r) begin
      if (rd_idx_r == found_idx_r) begin
        upd_rec.rank = '0;
        if (ram_rdata.count != CNT_MAX) begin
          upd_rec.count = ram_rdata.count + 1'b1;
        end
        if (ow_r) begin
          upd_rec.value = req_r.value;
        end
      end else if (ram_rdata.valid && (ram_rdata.rank < found_rank_r)) begin
        upd_rec.rank = ram_rdata.rank + 1'b1;
      end
    end else if (ins_r && (rd_idx_r == slot_r)) begin
      upd_rec.valid = 1'b1;
      upd_rec.key   = req_r.key;
      upd_rec.value = req_r.value;
      upd_rec.count = CNT_W'(1);
      upd_rec.rank  = '0;
    end else if (evict_r && (rd_idx_r == vic_idx_r)) begin
      upd_rec.valid = 1'b0;
    end else if (ram_rdata.valid) begin
      if (evict_r && (ram_rdata.rank > vic_rank_r)) begin
        rank_tmp = rank_tmp - 1'b1;
      end
      if (ins_r) begin
        rank_tmp = rank_tmp + 1'b1;
      end
      upd_rec.rank = rank_tmp;
    end
  end

  always_comb begin
    ram_we    = cmd.clear_wr || upd_en;
    ram_waddr = cmd.clear_wr ? addr : rd_idx_r;
    ram_wdata = cmd.clear_wr ? rec_t'('0) : upd_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      entry_cnt_r <= '0;
    end else begin
      rd_pend_r   <= cmd.rd;
      entry_cnt_r <= entry_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr;
    rd_upd_r <= cmd.mode_upd;
    if (cmd.load) begin
      req_r      <= req;
      found_ok_r <= 1'b0;
      inv_ok_r   <= 1'b0;
      vic_ok_r   <= 1'b0;
    end
    if (scan_en) begin
      if (ram_rdata.valid && (ram_rdata.key == req_r.key) && !found_ok_r) begin
        found_ok_r   <= 1'b1;
        found_idx_r  <= rd_idx_r;
        found_rank_r <= ram_rdata.rank;
        found_val_r  <= ram_rdata.value;
      end
      if (!ram_rdata.valid && !inv_ok_r) begin
        inv_ok_r  <= 1'b1;
        inv_idx_r <= rd_idx_r;
      end
      // Lowest count wins; on equal counts the larger rank is the older entry.
      if (ram_rdata.valid && (!vic_ok_r || (ram_rdata.count < vic_count_r) ||
          ((ram_rdata.count == vic_count_r) && (ram_rdata.rank > vic_rank_r)))) begin
        vic_ok_r    <= 1'b1;
        vic_idx_r   <= rd_idx_r;
        vic_rank_r  <= ram_rdata.rank;
        vic_count_r <= ram_rdata.count;
        vic_key_r   <= ram_rdata.key;
      end
    end
    if (cmd.decide) begin
      touch_r <= touch_nxt;
      ow_r    <= ow_nxt;
      evict_r <= evict_nxt;
      ins_r   <= ins_nxt;
      slot_r  <= slot_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== src/lfu_cache_lru_tiebreak.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// Key-value cache with least-frequently-used replacement, LRU tie-break.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in_if     sink       valid/ready            action, key, value
//  out_if    source     valid/ready            hit, read_value, evicted, evicted_key
//  APB       slave      psel/penable, pready=1 capacity register at byte address 0
//
//  Each request makes one scan of the entry RAM for the key and the victim, then
//  one read-modify-write sweep. Gets that miss and puts at zero capacity skip
//  the sweep. After reset the entry RAM is cleared before in_if.ready.
//  A result waiting in the output register holds back the next result only.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfuc_pkg::ADDR_W-1:0] paddr,
  input  logic [lfuc_pkg::APB_W-1:0]  pwdata,
  output logic [lfuc_pkg::APB_W-1:0]  prdata,
  output logic                        pready,
  lfuc_in_if.sink                     in_if,
  lfuc_out_if.source                  out_if
);
  import lfuc_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [CAP_W-1:0] capacity_r;
  logic             cfg_wr;

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] addr;
  req_t          req;
  res_t          res;

  logic out_valid_r;
  res_t out_res_r;
  logic out_busy;

  // Writes to any address other than the capacity register are ignored.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(APB_W - CAP_W){1'b0}}, capacity_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr && (paddr == ADDR_CAPACITY)) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  assign req.action = in_if.action;
  assign req.key    = in_if.key;
  assign req.value  = in_if.value;

  lfuc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_busy (out_busy),
    .status   (status),
    .cmd      (cmd),
    .addr     (addr)
  );

  lfuc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .addr     (addr),
    .req      (req),
    .capacity (capacity_r),
    .status   (status),
    .res      (res)
  );

  // Output register: a finished result waits here while the next request runs.
  assign out_busy = out_valid_r && !out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.hit         = out_res_r.hit;
  assign out_if.read_value  = out_res_r.read_value;
  assign out_if.evicted     = out_res_r.evicted;
  assign out_if.evicted_key = out_res_r.evicted_key;

  // A transaction is followed by a busy cycle; only one request is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted while another is in progress");

  // The entry RAM is swept clean before the first request is taken.
  a_clear_first: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_if.ready)
    else $error("request port ready before the clearing sweep");

  // A result is either a hit or an eviction, never both.
  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.hit && out_if.evicted))
    else $error("result reports both a hit and an eviction");

  // A new result is loaded only when the output register can take it.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_busy)
    else $error("result register overwritten before it was taken");

endmodule
